FILE: rtl/ntab_pkg.sv
`timescale 1ns / 1ps
package ntab_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  localparam logic [1:0] KIND_EXACT     = 2'd0;
  localparam logic [1:0] KIND_IP_ONLY   = 2'd1;
  localparam logic [1:0] KIND_PORT_ONLY = 2'd2;
  localparam logic [1:0] KIND_BOTH_WILD = 2'd3;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_DUP     = 2'd1;
  localparam logic [1:0] STAT_INVALID = 2'd2;
  localparam logic [1:0] STAT_FULL    = 2'd3;

  localparam logic [1:0] LVL_NONE = 2'd0;
  localparam logic [1:0] LVL_PORT = 2'd1;
  localparam logic [1:0] LVL_IP   = 2'd2;
  localparam logic [1:0] LVL_EXACT = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] key_ip;
    logic [15:0] key_port;
    logic [31:0] out_ip;
    logic [15:0] out_port;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic rule_hit;
    logic exact_hit;
    logic ip_hit;
    logic port_hit;
  } match_t;

endpackage

FILE: rtl/ntab_ram.sv
`timescale 1ns / 1ps
module ntab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/ntab_match.sv
`timescale 1ns / 1ps
module ntab_match (
  input  ntab_pkg::entry_t entry,
  input  logic [1:0]       probe_kind,
  input  logic [31:0]      probe_ip,
  input  logic [15:0]      probe_port,
  output ntab_pkg::match_t hit
);
  import ntab_pkg::*;

  logic ip_eq;
  logic port_eq;

  assign ip_eq   = (entry.key_ip == probe_ip);
  assign port_eq = (entry.key_port == probe_port);

  assign hit.rule_hit  = (entry.kind == probe_kind) && ip_eq && port_eq;
  assign hit.exact_hit = (entry.kind == KIND_EXACT) && ip_eq && port_eq;
  assign hit.ip_hit    = (entry.kind == KIND_IP_ONLY) && ip_eq && (entry.key_port == 16'd0);
  assign hit.port_hit  = (entry.kind == KIND_PORT_ONLY) && port_eq && (entry.key_ip == 32'd0);

endmodule

FILE: rtl/nat_wildcard_rule_table_top.sv
`timescale 1ns / 1ps
// NAT rule table with wildcard match.
// Input channel s_*: one item is an insert (s_tuser = 0) or a lookup (s_tuser = 1).
// An insert adds or replaces a rule (exact, ip with any port, any ip with port);
// a lookup gives the translation of the best matching rule, exact first, then
// ip-only, then port-only. Every item gives exactly one result on m_*.
// Each item scans the whole table held in block RAM, one entry a cycle
// through a single compare unit; a both-wildcard insert skips the scan.
// s_tready is high only while no item is in work.
// The next item may be accepted while a result still waits in the output
// register; if the receiver holds m_tready low, the following item stalls in
// its last cycle until the output register is free.
// Reset clears all entry valid bits at once, so the table is empty right after
// reset and no clearing pass is needed; any pending result is dropped.
module nat_wildcard_rule_table_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [103:0] s_tdata,  // rule_kind, match_ip, match_port, new_ip, new_port
  input  logic [0:0]   s_tuser,  // action
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [55:0]  m_tdata,  // result_ip, result_port, status
  output logic [0:0]   m_tuser   // found
);
  import ntab_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0] state;

  logic        op_action;
  logic [1:0]  op_kind;
  logic [31:0] op_ip;
  logic [15:0] op_port;
  logic [31:0] op_new_ip;
  logic [15:0] op_new_port;

  logic [CNT_W-1:0] cnt;
  logic             chk_ok;
  logic             chk_vld;
  logic [IDX_W-1:0] chk_idx;

  logic [TABLE_ENTRIES-1:0] valid_q;

  logic             dup_found;
  logic [IDX_W-1:0] dup_idx;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic [1:0]       lvl;
  logic [31:0]      hit_ip;
  logic [15:0]      hit_port;

  logic [1:0]  in_kind;
  logic [31:0] in_ip;
  logic [15:0] in_port;
  logic [31:0] key_ip;
  logic [15:0] key_port;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [ENTRY_W-1:0] rd_word;
  entry_t           rd_entry;
  match_t           hit;
  logic [1:0]       new_lvl;
  logic             scan_done;

  logic             out_free;
  logic             fin_go;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_entry;
  logic [1:0]       fin_status;

  assign in_kind = s_tdata[1:0];
  assign in_ip   = s_tdata[33:2];
  assign in_port = s_tdata[49:34];
  assign key_ip   = (in_kind == KIND_PORT_ONLY) ? 32'd0 : in_ip;
  assign key_port = (in_kind == KIND_IP_ONLY) ? 16'd0 : in_port;

  assign s_tready = (state == S_IDLE);

  assign rd_en     = (state == S_SCAN) && (cnt < CNT_W'(TABLE_ENTRIES));
  assign rd_addr   = cnt[IDX_W-1:0];
  assign rd_entry  = entry_t'(rd_word);
  assign scan_done = (state == S_SCAN) && (cnt == CNT_W'(TABLE_ENTRIES));

  ntab_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_entry),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_word)
  );

  ntab_match u_match (
    .entry     (rd_entry),
    .probe_kind(op_kind),
    .probe_ip  (op_ip),
    .probe_port(op_port),
    .hit       (hit)
  );

  always_comb begin
    if (hit.exact_hit) begin
      new_lvl = LVL_EXACT;
    end else if (hit.ip_hit) begin
      new_lvl = LVL_IP;
    end else if (hit.port_hit) begin
      new_lvl = LVL_PORT;
    end else begin
      new_lvl = LVL_NONE;
    end
  end

  assign out_free = !m_tvalid || m_tready;
  assign fin_go   = (state == S_FINISH) && out_free;

  assign wr_en = fin_go && (op_action == ACT_INSERT) && (op_kind != KIND_BOTH_WILD)
                 && (dup_found || free_found);
  assign wr_addr = dup_found ? dup_idx : free_idx;
  assign wr_entry.kind     = op_kind;
  assign wr_entry.key_ip   = op_ip;
  assign wr_entry.key_port = op_port;
  assign wr_entry.out_ip   = op_new_ip;
  assign wr_entry.out_port = op_new_port;

  always_comb begin
    if (op_action == ACT_LOOKUP) begin
      fin_status = STAT_OK;
    end else if (op_kind == KIND_BOTH_WILD) begin
      fin_status = STAT_INVALID;
    end else if (dup_found) begin
      fin_status = STAT_DUP;
    end else if (free_found) begin
      fin_status = STAT_OK;
    end else begin
      fin_status = STAT_FULL;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cnt     <= '0;
      chk_ok  <= 1'b0;
      valid_q <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          cnt    <= '0;
          chk_ok <= 1'b0;
          if (s_tvalid) begin
            if (s_tuser[0] == ACT_INSERT && in_kind == KIND_BOTH_WILD) begin
              state <= S_FINISH;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          chk_ok <= rd_en;
          if (rd_en) begin
            cnt <= cnt + CNT_W'(1);
          end
          if (scan_done) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (wr_en && !dup_found) begin
        valid_q[free_idx] <= 1'b1;
      end
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op_action   <= s_tuser[0];
      op_kind     <= in_kind;
      op_new_ip   <= s_tdata[81:50];
      op_new_port <= s_tdata[97:82];
      if (s_tuser[0] == ACT_INSERT) begin
        op_ip   <= key_ip;
        op_port <= key_port;
      end else begin
        op_ip   <= in_ip;
        op_port <= in_port;
      end
    end
  end

  // scan results
  always_ff @(posedge clk) begin
    if (rd_en) begin
      chk_vld <= valid_q[rd_addr];
      chk_idx <= rd_addr;
    end
    if (state == S_IDLE) begin
      dup_found  <= 1'b0;
      free_found <= 1'b0;
      lvl        <= LVL_NONE;
      hit_ip     <= 32'd0;
      hit_port   <= 16'd0;
    end else if (state == S_SCAN && chk_ok) begin
      if (!chk_vld) begin
        if (!free_found) begin
          free_found <= 1'b1;
          free_idx   <= chk_idx;
        end
      end else if (op_action == ACT_INSERT) begin
        if (hit.rule_hit && !dup_found) begin
          dup_found <= 1'b1;
          dup_idx   <= chk_idx;
        end
      end else if (new_lvl > lvl) begin
        lvl      <= new_lvl;
        hit_ip   <= rd_entry.out_ip;
        hit_port <= rd_entry.out_port;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fin_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      m_tuser[0]      <= (lvl != LVL_NONE);
      m_tdata[31:0]   <= hit_ip;
      m_tdata[47:32]  <= hit_port;
      m_tdata[49:48]  <= fin_status;
      m_tdata[55:50]  <= 6'd0;
    end
  end

endmodule

FILE: rtl/ntab_checker.sv
`timescale 1ns / 1ps
module ntab_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [55:0]  m_tdata,
  input logic [0:0]   m_tuser
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // one item in work at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("item accepted while busy");

  // a hit is a lookup, so its status is ok
  a_hit_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[49:48] == 2'd0)
    else $error("hit with non-ok status");

  // a miss or an insert carries no translation
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[47:0] == 48'd0)
    else $error("translation on a miss");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("result or busy after reset");

endmodule

bind nat_wildcard_rule_table_top ntab_checker u_ntab_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);

FILE: tb/tb_nat_wildcard_rule_table_top.sv
`timescale 1ns / 1ps
module tb_nat_wildcard_rule_table_top;
  import ntab_pkg::*;

  localparam int ITEMS_TOTAL = 1000;
  localparam int IDLE_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = TABLE_ENTRIES + 16;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int NO_ENTRY = -1;
  localparam int POOL_SIZE = 12;

  typedef struct packed {
    logic        action;
    logic [1:0]  kind;
    logic [31:0] match_ip;
    logic [15:0] match_port;
    logic [31:0] new_ip;
    logic [15:0] new_port;
  } xlate_req_t;

  typedef struct packed {
    logic        found;
    logic [31:0] result_ip;
    logic [15:0] result_port;
    logic [1:0]  status;
  } xlate_resp_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [103:0] s_tdata = '0;  // rule_kind, match_ip, match_port, new_ip, new_port
  logic [0:0]   s_tuser = '0;  // action
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [55:0]  m_tdata;       // result_ip, result_port, status
  logic [0:0]   m_tuser;       // found

  nat_wildcard_rule_table_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // shadow copy of the rule table
  logic        rule_valid [TABLE_ENTRIES];
  logic [1:0]  rule_kind  [TABLE_ENTRIES];
  logic [31:0] rule_key_ip [TABLE_ENTRIES];
  logic [15:0] rule_key_port [TABLE_ENTRIES];
  logic [31:0] rule_out_ip [TABLE_ENTRIES];
  logic [15:0] rule_out_port [TABLE_ENTRIES];

  xlate_req_t  pending_items[$];
  xlate_resp_t expected_xlates[$];
  xlate_req_t  cur_item;

  logic [31:0] ip_pool [POOL_SIZE];
  logic [15:0] port_pool [POOL_SIZE];

  int n_total;
  int n_sent = 0;
  int n_results = 0;
  int err_count = 0;
  int gap_left = 0;
  int stall_left = 0;
  int idle_cycles = 0;
  int roll;
  bit pressure_done = 1'b0;
  int insert_status_count [4];
  int hits_exact = 0;
  int hits_ip = 0;
  int hits_port = 0;
  int misses = 0;

  function automatic int find_rule(logic [1:0] kind, logic [31:0] ip, logic [15:0] port);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (rule_valid[i] && rule_kind[i] == kind && rule_key_ip[i] == ip &&
          rule_key_port[i] == port)
        return i;
    end
    return NO_ENTRY;
  endfunction

  function automatic int find_free_slot();
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (!rule_valid[i])
        return i;
    end
    return NO_ENTRY;
  endfunction

  // applies one item to the shadow table and gives the translation it yields
  function automatic xlate_resp_t translate_item(xlate_req_t rq);
    xlate_resp_t rs;
    logic [31:0] kip;
    logic [15:0] kport;
    int idx;
    rs = '0;
    rs.status = STAT_OK;
    if (rq.action == ACT_INSERT) begin
      if (rq.kind == KIND_BOTH_WILD) begin
        rs.status = STAT_INVALID;
      end else begin
        kip = (rq.kind == KIND_PORT_ONLY) ? 32'd0 : rq.match_ip;
        kport = (rq.kind == KIND_IP_ONLY) ? 16'd0 : rq.match_port;
        idx = find_rule(rq.kind, kip, kport);
        if (idx != NO_ENTRY) begin
          rs.status = STAT_DUP;
        end else begin
          idx = find_free_slot();
          if (idx == NO_ENTRY) begin
            rs.status = STAT_FULL;
          end else begin
            rule_valid[idx] = 1'b1;
            rule_kind[idx] = rq.kind;
            rule_key_ip[idx] = kip;
            rule_key_port[idx] = kport;
          end
        end
        if (idx != NO_ENTRY) begin
          rule_out_ip[idx] = rq.new_ip;
          rule_out_port[idx] = rq.new_port;
        end
      end
      insert_status_count[rs.status]++;
    end else begin
      idx = find_rule(KIND_EXACT, rq.match_ip, rq.match_port);
      if (idx != NO_ENTRY) begin
        hits_exact++;
      end else begin
        idx = find_rule(KIND_IP_ONLY, rq.match_ip, 16'd0);
        if (idx != NO_ENTRY) begin
          hits_ip++;
        end else begin
          idx = find_rule(KIND_PORT_ONLY, 32'd0, rq.match_port);
          if (idx != NO_ENTRY)
            hits_port++;
          else
            misses++;
        end
      end
      if (idx != NO_ENTRY) begin
        rs.found = 1'b1;
        rs.result_ip = rule_out_ip[idx];
        rs.result_port = rule_out_port[idx];
      end
    end
    return rs;
  endfunction

  task automatic add_insert(logic [1:0] kind, logic [31:0] ip, logic [15:0] port,
                            logic [31:0] nip, logic [15:0] nport);
    xlate_req_t rq;
    rq.action = ACT_INSERT;
    rq.kind = kind;
    rq.match_ip = ip;
    rq.match_port = port;
    rq.new_ip = nip;
    rq.new_port = nport;
    pending_items.insert(pending_items.size(), rq);
  endtask

  // kind and translation are ignored by a lookup, so they carry noise
  task automatic add_lookup(logic [31:0] ip, logic [15:0] port);
    xlate_req_t rq;
    rq.action = ACT_LOOKUP;
    rq.kind = 2'($urandom_range(3));
    rq.match_ip = ip;
    rq.match_port = port;
    rq.new_ip = $urandom;
    rq.new_port = 16'($urandom);
    pending_items.insert(pending_items.size(), rq);
  endtask

  function automatic logic [31:0] pick_ip();
    if ($urandom_range(99) < 80)
      return ip_pool[$urandom_range(POOL_SIZE - 1)];
    return $urandom;
  endfunction

  function automatic logic [15:0] pick_port();
    if ($urandom_range(99) < 80)
      return port_pool[$urandom_range(POOL_SIZE - 1)];
    return 16'($urandom);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if ((n_sent / 100) % 3 == 1)
      return 0;
    if (r < 50)
      return 0;
    if (r < 85)
      return $urandom_range(3, 1);
    if (r < 97)
      return $urandom_range(20, 4);
    return $urandom_range(150, 50);
  endfunction

  task automatic note_mismatch(string field, logic [31:0] got, logic [31:0] exp);
    $display("mismatch on result %0d: %s got 0x%0h, expected 0x%0h",
             n_results, field, got, exp);
    err_count++;
  endtask

  task automatic check_result();
    xlate_resp_t got;
    xlate_resp_t exp;
    got.found = m_tuser[0];
    got.result_ip = m_tdata[31:0];
    got.result_port = m_tdata[47:32];
    got.status = m_tdata[49:48];
    if (expected_xlates.size() == 0) begin
      $display("unexpected result: found %0d ip 0x%0h port 0x%0h status %0d",
               got.found, got.result_ip, got.result_port, got.status);
      err_count++;
    end else begin
      exp = expected_xlates.pop_front();
      if (got.found !== exp.found)
        note_mismatch("found", 32'(got.found), 32'(exp.found));
      if (got.result_ip !== exp.result_ip)
        note_mismatch("result_ip", got.result_ip, exp.result_ip);
      if (got.result_port !== exp.result_port)
        note_mismatch("result_port", 32'(got.result_port), 32'(exp.result_port));
      if (got.status !== exp.status)
        note_mismatch("status", 32'(got.status), 32'(exp.status));
    end
    n_results++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_xlates.insert(expected_xlates.size(), translate_item(cur_item));
        n_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          s_tvalid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= cur_item.action;
          s_tdata <= {6'd0, cur_item.new_port, cur_item.new_ip, cur_item.match_port,
                      cur_item.match_ip, cur_item.kind};
          gap_left <= pick_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready)
        check_result();
      if (!pressure_done && n_results >= 300) begin
        pressure_done <= 1'b1;
        stall_left <= HOLD_OFF_CYCLES;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        m_tready <= 1'b0;
      end else begin
        roll = $urandom_range(99);
        if ((n_results / 150) % 4 != 2 && roll < 4) begin
          stall_left <= (roll == 0) ? $urandom_range(200, 20) : $urandom_range(5, 1);
          m_tready <= 1'b0;
        end else begin
          m_tready <= 1'b1;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [31:0] ip_a;
    logic [31:0] ip_b;
    logic [1:0] kind;
    int n_random;
    for (int i = 0; i < TABLE_ENTRIES; i++)
      rule_valid[i] = 1'b0;
    for (int i = 0; i < 4; i++)
      insert_status_count[i] = 0;
    ip_a = 32'h0a00_0001;
    ip_b = 32'hc0a8_0102;
    ip_pool[0] = 32'd0;
    ip_pool[1] = 32'hffff_ffff;
    ip_pool[2] = ip_a;
    ip_pool[3] = ip_b;
    port_pool[0] = 16'd0;
    port_pool[1] = 16'hffff;
    port_pool[2] = 16'd80;
    port_pool[3] = 16'd443;
    for (int i = 4; i < POOL_SIZE; i++) begin
      ip_pool[i] = $urandom;
      port_pool[i] = 16'($urandom);
    end

    // extremes, each rule kind, priorities, duplicates and a rejected rule
    add_insert(KIND_EXACT, 32'd0, 16'd0, 32'hffff_ffff, 16'hffff);
    add_insert(KIND_EXACT, 32'hffff_ffff, 16'hffff, 32'd0, 16'd0);
    add_lookup(32'd0, 16'd0);
    add_lookup(32'hffff_ffff, 16'hffff);
    add_insert(KIND_IP_ONLY, ip_a, 16'd1234, 32'h1111_2222, 16'd5000);
    add_insert(KIND_IP_ONLY, ip_a, 16'd999, 32'h3333_4444, 16'd5001);
    add_insert(KIND_PORT_ONLY, 32'd5, 16'd80, 32'h5555_6666, 16'd6000);
    add_insert(KIND_PORT_ONLY, 32'd77, 16'd80, 32'h7777_8888, 16'd6001);
    add_insert(KIND_BOTH_WILD, ip_b, 16'd443, 32'h9999_aaaa, 16'd7000);
    add_lookup(ip_a, 16'd7);
    add_lookup(32'h0102_0304, 16'd80);
    add_lookup(32'h0102_0304, 16'd81);
    add_insert(KIND_EXACT, ip_a, 16'd80, 32'hbbbb_cccc, 16'd8000);
    add_lookup(ip_a, 16'd80);
    add_insert(KIND_PORT_ONLY, 32'd0, 16'd443, 32'hdddd_eeee, 16'd9000);
    add_insert(KIND_IP_ONLY, ip_b, 16'd0, 32'h0f0f_0f0f, 16'd9001);
    add_lookup(ip_b, 16'd443);
    add_lookup(32'h0102_0304, 16'd443);
    add_insert(KIND_EXACT, 32'd0, 16'd0, 32'h1234_5678, 16'h9abc);
    add_lookup(32'd0, 16'd0);
    add_insert(KIND_BOTH_WILD, 32'hffff_ffff, 16'hffff, 32'hffff_ffff, 16'hffff);
    add_lookup(ip_b, 16'd1);

    // mostly keys from small pools so rules collide, hit and fill the table
    n_random = ITEMS_TOTAL - pending_items.size();
    for (int i = 0; i < n_random; i++) begin
      if ($urandom_range(99) < 45) begin
        case ($urandom_range(12))
          0:       kind = KIND_BOTH_WILD;
          1, 2, 3: kind = KIND_IP_ONLY;
          4, 5, 6: kind = KIND_PORT_ONLY;
          default: kind = KIND_EXACT;
        endcase
        add_insert(kind, pick_ip(), pick_port(), $urandom, 16'($urandom));
      end else begin
        add_lookup(pick_ip(), pick_port());
      end
    end
    n_total = pending_items.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    while (n_sent < n_total || expected_xlates.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d items; inserts: %0d new, %0d replaced, %0d rejected, %0d table full",
             n_sent, insert_status_count[STAT_OK], insert_status_count[STAT_DUP],
             insert_status_count[STAT_INVALID], insert_status_count[STAT_FULL]);
    $display("lookups: %0d exact hits, %0d ip-only hits, %0d port-only hits, %0d misses",
             hits_exact, hits_ip, hits_port, misses);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
